[rtl/core/urit_pkg.sv]
// shared types and constants for the unique row index table
package urit_pkg;

	localparam int MAX_UNIQUE  = 256;
	localparam int MAX_COLUMNS = 4;
	localparam int ELEM_BITS   = 16;

	localparam int ROW_BITS = MAX_COLUMNS * ELEM_BITS;
	localparam int IDX_BITS = $clog2(MAX_UNIQUE);
	localparam int CNT_BITS = IDX_BITS + 1;

	typedef struct packed {
		logic        first_row;
		logic [15:0] elem_0;
		logic [15:0] elem_1;
		logic [15:0] elem_2;
		logic [15:0] elem_3;
	} in_word_t;

	typedef struct packed {
		logic [8:0] row_index;
		logic       is_new;
		logic       overflow;
	} out_word_t;

	// ring control from the sequencer to every cell
	typedef struct packed {
		logic shift;
		logic load;
	} ring_ctl_t;

	typedef logic [ROW_BITS-1:0] row_t;

endpackage

[rtl/core/urit_cell.sv]
// one stage of the rotating ring of stored unique rows
module urit_cell (
	input  logic              clk,
	input  urit_pkg::ring_ctl_t ctl,
	input  urit_pkg::row_t    nbr_row,
	input  urit_pkg::row_t    load_row,
	output urit_pkg::row_t    row
);
	import urit_pkg::*;

	row_t row_q;

	// contents stay undefined until written, so no reset
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			row_q <= ctl.load ? load_row : nbr_row;
		end
	end

	assign row = row_q;

endmodule

[rtl/core/urit_ctrl.sv]
// scan sequencer, compare at the ring head, config register and output register
module urit_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  urit_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output urit_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  urit_pkg::row_t      head_row,
	output urit_pkg::row_t      query_row,
	output urit_pkg::ring_ctl_t ring_ctl,
	output urit_pkg::ring_ctl_t ring_hold
);
	import urit_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [2:0]          cols_q;
	logic [CNT_BITS-1:0] count_q;
	logic [IDX_BITS-1:0] step_q;
	logic                hit_q;
	logic [CNT_BITS-1:0] idx_q;
	row_t                query_q;
	row_t                mask_q;
	logic                out_valid_q;
	out_word_t           out_data_q;

	logic [15:0]         elems [4];
	row_t                in_row;
	row_t                in_mask;
	logic [2:0]          n_cols;
	logic                accept;
	logic                head_match;
	logic                step_in_use;
	logic                step_at_end;
	logic                last_step;
	logic                out_free;
	logic [CNT_BITS-1:0] step_ext;

	assign elems[0] = in_data.elem_0;
	assign elems[1] = in_data.elem_1;
	assign elems[2] = in_data.elem_2;
	assign elems[3] = in_data.elem_3;

	// zero columns acts as one, too many saturates
	always_comb begin
		if (cols_q == 3'd0) begin
			n_cols = 3'd1;
		end else if (cols_q > 3'(MAX_COLUMNS)) begin
			n_cols = 3'(MAX_COLUMNS);
		end else begin
			n_cols = cols_q;
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			in_row[c*ELEM_BITS +: ELEM_BITS]  = elems[c][ELEM_BITS-1:0];
			in_mask[c*ELEM_BITS +: ELEM_BITS] = {ELEM_BITS{(3'(c) < n_cols)}};
		end
	end

	assign accept      = (state_q == ST_IDLE) && in_valid;
	assign step_ext    = {1'b0, step_q};
	assign head_match  = ((head_row ^ query_q) & mask_q) == '0;
	assign step_in_use = step_ext < count_q;
	assign step_at_end = step_ext == count_q;
	assign last_step   = step_q == IDX_BITS'(MAX_UNIQUE - 1);
	assign out_free    = !out_valid_q || !out_stall;

	// append lands in the tail cell when the head holds the first free slot
	assign ring_ctl.shift  = state_q == ST_SCAN;
	assign ring_ctl.load   = (state_q == ST_SCAN) && !hit_q && step_at_end;
	assign ring_hold.shift = state_q == ST_SCAN;
	assign ring_hold.load  = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cols_q      <= 3'd4;
			count_q     <= '0;
			step_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cols_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.first_row) begin
							count_q <= '0;
						end
						hit_q   <= 1'b0;
						step_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step_in_use && !hit_q && head_match) begin
						hit_q <= 1'b1;
					end
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (!hit_q && (count_q != CNT_BITS'(MAX_UNIQUE))) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= in_row;
			mask_q  <= in_mask;
		end
		if ((state_q == ST_SCAN) && step_in_use && !hit_q && head_match) begin
			idx_q <= step_ext + 1'b1;
		end
		if ((state_q == ST_DONE) && out_free) begin
			if (hit_q) begin
				out_data_q.row_index <= 9'(idx_q);
				out_data_q.is_new    <= 1'b0;
				out_data_q.overflow  <= 1'b0;
			end else if (count_q == CNT_BITS'(MAX_UNIQUE)) begin
				out_data_q.row_index <= 9'd0;
				out_data_q.is_new    <= 1'b0;
				out_data_q.overflow  <= 1'b1;
			end else begin
				out_data_q.row_index <= 9'(count_q + 1'b1);
				out_data_q.is_new    <= 1'b1;
				out_data_q.overflow  <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign query_row = query_q;

endmodule

[rtl/core/unique_row_index_table.sv]
// top level of the unique row index table: ring of row cells and scan sequencer
//
// channel   direction  handshake                 word
// in        input      in_valid / in_stall       first_row, elem_0..elem_3
// out       output     out_valid / out_stall     row_index, is_new, overflow
// cfg       input      cfg_we (no wait)          columns_in_use, 3 bits
//
// after accept the sequencer scans the ring, then in its done state loads the result
// word into the output register and returns to idle for the next row; in the scan
// the stored rows rotate once around the ring of cells, one cell per cycle, and
// only the head cell is compared with the query
// a new row is written into the tail cell on the step where the head holds the
// first free slot, so the ring is back in order when the rotation ends
// reset clears the row count and sets columns_in_use to 4; the cells are not cleared
// in_stall is high from accept until the result is loaded; a stalled result waits in
// the output register while the next row is already accepted and scanned
module unique_row_index_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  urit_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output urit_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata
);
	import urit_pkg::*;

	// ring of stored rows, cell 0 is the head
	row_t      cell_row [MAX_UNIQUE];
	row_t      query_row;
	ring_ctl_t ring_ctl;
	ring_ctl_t ring_hold;

	urit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head_row  (cell_row[0]),
		.query_row (query_row),
		.ring_ctl  (ring_ctl),
		.ring_hold (ring_hold)
	);

	// each cell takes its upper neighbor; the tail takes the head or a new row
	for (genvar i = 0; i < MAX_UNIQUE; i++) begin : g_cell
		if (i == MAX_UNIQUE - 1) begin : g_tail
			urit_cell u_cell (
				.clk      (clk),
				.ctl      (ring_ctl),
				.nbr_row  (cell_row[0]),
				.load_row (query_row),
				.row      (cell_row[i])
			);
		end else begin : g_body
			urit_cell u_cell (
				.clk      (clk),
				.ctl      (ring_hold),
				.nbr_row  (cell_row[i+1]),
				.load_row (query_row),
				.row      (cell_row[i])
			);
		end
	end

endmodule
